FILE: hw/rtl/gwmm_pkg.sv
// Package for the gray window min/max filter.
// Holds register codes, defaults, controller states and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none
package gwmm_pkg;

	localparam int DefMaxWidth  = 4096;
	localparam int DefMaxHeight = 4096;
	localparam int DefMaxRadius = 8;

	localparam int CfgDataW = 13;
	localparam int CfgIdxW  = 2;
	localparam int PixW     = 8;

	localparam logic [12:0] RstWidth  = 13'd640;
	localparam logic [12:0] RstHeight = 13'd480;
	localparam logic [3:0]  RstRadius = 4'd1;
	localparam logic [PixW-1:0] PixMax = 8'd255;

	typedef enum logic [CfgIdxW-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RADIUS = 2'd2,
		REG_MODE   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_WAIT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic start;
		logic rd;
		logic deliver;
	} ctl_cmd_t;

	typedef struct packed {
		logic emit;
		logic rd_last;
	} ctl_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/gwmm_ifs.sv
// Request and result channel interfaces of the gray window min/max filter.
// Depends on gwmm_pkg for the pixel width.
`timescale 1ns / 1ps
`default_nettype none
interface gwmm_in_if;
	import gwmm_pkg::*;
	logic            valid;
	logic            ready;
	logic [PixW-1:0] pixel_in;
	logic            flush;
	modport source (output valid, output pixel_in, output flush, input ready);
	modport sink (input valid, input pixel_in, input flush, output ready);
endinterface

interface gwmm_out_if;
	import gwmm_pkg::*;
	logic            valid;
	logic            ready;
	logic [PixW-1:0] pixel_out;
	logic            frame_last;
	modport source (output valid, output pixel_out, output frame_last, input ready);
	modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/gwmm_ctrl.sv
// Controller state machine of the gray window min/max filter.
// Depends on gwmm_pkg; drives the datapath by command struct.
`timescale 1ns / 1ps
`default_nettype none
module gwmm_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire gwmm_pkg::ctl_sts_t  sts,
	output gwmm_pkg::ctl_cmd_t       cmd,
	output gwmm_pkg::state_t         state
);
	import gwmm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && sts.emit) state_d = S_READ;
			end
			S_READ: begin
				if (sts.rd_last) state_d = S_WAIT;
			end
			S_WAIT: state_d = S_OUT;
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd         = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				cmd.start  = in_valid && sts.emit;
			end
			S_READ: cmd.rd = 1'b1;
			S_WAIT: ;
			S_OUT: begin
				out_valid   = 1'b1;
				cmd.deliver = out_ready;
			end
			default: ;
		endcase
	end

	assign state = state_q;

endmodule
`default_nettype wire

FILE: hw/rtl/gwmm_dp.sv
// Datapath of the gray window min/max filter: registers, counters, line store,
// window walk and accumulator. Depends on gwmm_pkg; driven by gwmm_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module gwmm_dp #(
	parameter int MAX_WIDTH  = gwmm_pkg::DefMaxWidth,
	parameter int MAX_HEIGHT = gwmm_pkg::DefMaxHeight,
	parameter int MAX_RADIUS = gwmm_pkg::DefMaxRadius
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gwmm_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [gwmm_pkg::CfgDataW-1:0] cfg_wdata,
	input  wire logic [gwmm_pkg::PixW-1:0]     pixel_in,
	input  wire logic                          flush,
	input  wire gwmm_pkg::ctl_cmd_t            cmd,
	output gwmm_pkg::ctl_sts_t                 sts,
	output logic [gwmm_pkg::PixW-1:0]          pixel_out,
	output logic                               frame_last
);
	import gwmm_pkg::*;

	localparam int Ring  = 2 * MAX_RADIUS + 2;
	localparam int RingW = $clog2(Ring);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int ORW   = $clog2(MAX_HEIGHT);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int JW    = $clog2(2 * MAX_RADIUS + 1);
	localparam int KW    = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
	localparam int SXW   = CW + 2;
	localparam int SYW   = ORW + 2;
	localparam int AW    = RingW + CW;

	logic [CfgDataW-1:0] w_cfg_q, h_cfg_q;
	logic [3:0]          r_cfg_q;
	logic                mode_q;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [RW-1:0] r_eff;
	logic [KW-1:0] lag;

	logic [CW-1:0]    in_col_q, out_col_q;
	logic [HW-1:0]    in_row_q;
	logic [ORW-1:0]   out_row_q;
	logic [RingW-1:0] in_ring_q, out_ring_q, yring_q;
	logic [KW-1:0]    k_q;
	logic [JW-1:0]    jx_q, jy_q;
	logic [PixW-1:0]  acc_q, rdata_s1;
	logic             rd_vld_s1;

	logic [PixW-1:0] mem [Ring * (2 ** CW)];

	logic             frame_end, clr, wr;
	logic signed [SXW-1:0] xs, w_top;
	logic signed [SYW-1:0] yc, h_top;
	logic [CW-1:0]    xx;
	logic [JW-1:0]    span;
	logic             row_end;

	always_comb begin
		if (w_cfg_q == '0) w_eff = WW'(1);
		else if ({1'b0, w_cfg_q} > (CfgDataW + 1)'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(w_cfg_q);
		if (h_cfg_q == '0) h_eff = HW'(1);
		else if ({1'b0, h_cfg_q} > (CfgDataW + 1)'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
		else h_eff = HW'(h_cfg_q);
		if ({1'b0, r_cfg_q} > 5'(MAX_RADIUS) + 5'd0) r_eff = RW'(MAX_RADIUS);
		else r_eff = RW'(r_cfg_q);
	end

	assign lag       = KW'(KW'(r_eff) * KW'(w_eff)) + KW'(r_eff);
	assign frame_end = (in_row_q >= h_eff);
	assign sts.emit  = frame_end || (!flush && (k_q >= lag));
	assign wr        = cmd.accept && !frame_end && !flush;
	assign clr       = cfg_we || (cmd.deliver && frame_last);
	assign span      = JW'({r_eff, 1'b0});
	assign row_end   = (jx_q == span);
	assign sts.rd_last = row_end && (jy_q == span);

	assign w_top = SXW'(w_eff) - SXW'(1);
	assign xs    = $signed(SXW'(out_col_q)) - $signed(SXW'(r_eff)) + $signed(SXW'(jx_q));
	assign xx    = (xs < 0) ? '0 : ((xs > w_top) ? CW'(w_top) : CW'(xs));
	assign h_top = SYW'(h_eff) - SYW'(1);
	assign yc    = $signed(SYW'(out_row_q)) - $signed(SYW'(r_eff))
		+ $signed(SYW'(jy_q)) + SYW'(1);

	assign frame_last = (SYW'(out_row_q) == h_top) && (SXW'(out_col_q) == w_top);
	assign pixel_out  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_cfg_q <= RstWidth;
			h_cfg_q <= RstHeight;
			r_cfg_q <= RstRadius;
			mode_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIDTH:  w_cfg_q <= cfg_wdata;
				REG_HEIGHT: h_cfg_q <= cfg_wdata;
				REG_RADIUS: r_cfg_q <= cfg_wdata[3:0];
				REG_MODE:   mode_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_ring_q  <= '0;
			k_q        <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_ring_q <= '0;
		end else if (clr) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_ring_q  <= '0;
			k_q        <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_ring_q <= '0;
		end else begin
			if (wr) begin
				k_q <= k_q + KW'(1);
				if (WW'(in_col_q) + WW'(1) >= w_eff) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + HW'(1);
					in_ring_q <= (in_ring_q == RingW'(Ring - 1)) ? '0 : in_ring_q + RingW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (cmd.deliver) begin
				if (WW'(out_col_q) + WW'(1) >= w_eff) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + ORW'(1);
					out_ring_q <= (out_ring_q == RingW'(Ring - 1)) ? '0
						: out_ring_q + RingW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			jx_q  <= '0;
			jy_q  <= '0;
			acc_q <= mode_q ? PixMax : '0;
			if (ORW'(out_row_q) >= ORW'(r_eff)) begin
				yring_q <= (out_ring_q >= RingW'(r_eff)) ? out_ring_q - RingW'(r_eff)
					: RingW'((RingW + 1)'(out_ring_q) + (RingW + 1)'(Ring)
					- (RingW + 1)'(r_eff));
			end else begin
				yring_q <= '0;
			end
		end else begin
			if (cmd.rd) begin
				if (row_end) begin
					jx_q <= '0;
					jy_q <= jy_q + JW'(1);
					if ((yc >= SYW'(1)) && (yc <= h_top)) begin
						yring_q <= (yring_q == RingW'(Ring - 1)) ? '0 : yring_q + RingW'(1);
					end
				end else begin
					jx_q <= jx_q + JW'(1);
				end
			end
			if (rd_vld_s1) begin
				if (mode_q ? (rdata_s1 < acc_q) : (rdata_s1 > acc_q)) acc_q <= rdata_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem[AW'({in_ring_q, in_col_q})] <= pixel_in;
		if (cmd.rd) rdata_s1 <= mem[AW'({yring_q, xx})];
	end

endmodule
`default_nettype wire

FILE: hw/rtl/gray_window_min_max_filter_core.sv
// Gray window min/max filter: accepts raster pixels, writes them into a ring of
// line buffers and walks the clamped square window once per result pixel. The
// block takes one request per cycle while no result is due; a request that
// releases a result occupies it for the walk over all (2*R+1)^2 window pixels,
// S_WAIT and the wait for the result to be taken, the walk set by the single
// line-store read port, one window pixel per cycle. Results trail the input by
// R rows plus R pixels; after the frame, flush requests release the pending
// results, the last one marked. No clearing pass: every window read hits a
// pixel of the current frame. Needs gwmm_pkg, gwmm_ifs, gwmm_ctrl, gwmm_dp.
`timescale 1ns / 1ps
`default_nettype none
module gray_window_min_max_filter_core #(
	parameter int MAX_WIDTH  = gwmm_pkg::DefMaxWidth,
	parameter int MAX_HEIGHT = gwmm_pkg::DefMaxHeight,
	parameter int MAX_RADIUS = gwmm_pkg::DefMaxRadius
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gwmm_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [gwmm_pkg::CfgDataW-1:0] cfg_wdata,
	gwmm_in_if.sink                            in_ch,
	gwmm_out_if.source                         out_ch
);
	import gwmm_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;
	state_t   state;

	gwmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd),
		.state     (state)
	);

	gwmm_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.pixel_in   (in_ch.pixel_in),
		.flush      (in_ch.flush),
		.cmd        (cmd),
		.sts        (sts),
		.pixel_out  (out_ch.pixel_out),
		.frame_last (out_ch.frame_last)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("request taken while a result is pending");

	a_read_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state == S_READ) |=> (state == S_READ || state == S_WAIT))
		else $error("window walk left early");

	a_wait_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state == S_WAIT) |=> out_ch.valid)
		else $error("result not shown after window walk");

endmodule
`default_nettype wire

FILE: tb/gray_window_min_max_filter_core_test.sv
// Self-checking bench for gray_window_min_max_filter_core: a tracker class keeps its own line
// store and raster counters and predicts every window max/min pixel from the accepted requests.
// Depends on gwmm_pkg, gwmm_ifs and the core RTL.
`timescale 1ns / 1ps
`default_nettype none
module gray_window_min_max_filter_core_test;
	import gwmm_pkg::*;

	localparam int RingRows = 2 * DefMaxRadius + 2;

	typedef struct packed {
		logic [PixW-1:0] level;
		logic            last;
	} window_pix_t;

	class window_tracker;
		logic [PixW-1:0] ring [RingRows*DefMaxWidth];
		int unsigned in_col, in_row, out_col, out_row;
		logic [12:0] width_reg, height_reg;
		logic [3:0] radius_reg;
		logic mode_reg;
		window_pix_t pending_pix[$];
		int mismatches;

		function new();
			foreach (ring[i]) ring[i] = '0;
			width_reg = RstWidth;
			height_reg = RstHeight;
			radius_reg = RstRadius;
			mode_reg = 1'b0;
			mismatches = 0;
			clear_pos();
		endfunction

		function void clear_pos();
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		endfunction

		function int eff_w();
			if (width_reg < 1) return 1;
			return width_reg > DefMaxWidth ? DefMaxWidth : width_reg;
		endfunction

		function int eff_h();
			if (height_reg < 1) return 1;
			return height_reg > DefMaxHeight ? DefMaxHeight : height_reg;
		endfunction

		function int eff_r();
			return radius_reg > DefMaxRadius ? DefMaxRadius : radius_reg;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CfgDataW-1:0] val);
			case (idx)
				REG_WIDTH: width_reg = val;
				REG_HEIGHT: height_reg = val;
				REG_RADIUS: radius_reg = val[3:0];
				REG_MODE: mode_reg = val[0];
			endcase
			clear_pos();
		endfunction

		function void predict_window();
			int w, h, r, yy, xx;
			logic [PixW-1:0] acc, v;
			window_pix_t p;
			w = eff_w();
			h = eff_h();
			r = eff_r();
			acc = mode_reg ? PixMax : '0;
			for (int dy = -r; dy <= r; dy++) begin
				yy = int'(out_row) + dy;
				yy = yy < 0 ? 0 : (yy > h - 1 ? h - 1 : yy);
				for (int dx = -r; dx <= r; dx++) begin
					xx = int'(out_col) + dx;
					xx = xx < 0 ? 0 : (xx > w - 1 ? w - 1 : xx);
					v = ring[(yy % RingRows) * DefMaxWidth + xx];
					if (mode_reg ? (v < acc) : (v > acc)) acc = v;
				end
			end
			p.level = acc;
			p.last = (out_row == h - 1) && (out_col == w - 1);
			pending_pix.push_back(p);
			if (p.last) clear_pos();
			else if (out_col + 1 >= w) begin
				out_col = 0;
				out_row++;
			end else out_col++;
		endfunction

		function void log_pixel(logic [PixW-1:0] level, logic fl);
			int unsigned w, h, r, k;
			w = eff_w();
			h = eff_h();
			r = eff_r();
			if (in_row >= h) begin
				predict_window();
				return;
			end
			if (fl) return;
			if (in_col >= w) in_col = 0;
			ring[(in_row % RingRows) * DefMaxWidth + in_col] = level;
			k = in_row * w + in_col;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (k >= r * w + r) predict_window();
		endfunction

		function void check_result(logic [PixW-1:0] level, logic last);
			window_pix_t e;
			if (pending_pix.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result pixel=%0d last=%0b", level, last);
				return;
			end
			e = pending_pix.pop_front();
			if (e.level !== level || e.last !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected pixel=%0d last=%0b, got pixel=%0d last=%0b",
						e.level, e.last, level, last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_wdata = '0;
	bit calm = 1'b0;
	int sent = 0;
	window_tracker tracker;

	gwmm_in_if in_ch ();
	gwmm_out_if out_ch ();

	gray_window_min_max_filter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #1 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.pixel_in = '0;
		in_ch.flush = 1'b0;
		out_ch.ready = 1'b0;
		tracker = new();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) tracker.write_reg(reg_idx_t'(cfg_index), cfg_wdata);
			if (in_ch.valid && in_ch.ready) tracker.log_pixel(in_ch.pixel_in, in_ch.flush);
			if (out_ch.valid && out_ch.ready)
				tracker.check_result(out_ch.pixel_out, out_ch.frame_last);
		end
	end

	// receiver: random stall bursts, none once calm
	always @(posedge clk) begin
		if (!arst_n || calm || $urandom_range(3) != 0) out_ch.ready <= 1'b1;
		else begin
			out_ch.ready <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
			out_ch.ready <= 1'b1;
		end
	end

	task automatic send_request(logic [PixW-1:0] level, logic fl);
		if (!calm && $urandom_range(4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pixel_in <= level;
		in_ch.flush <= fl;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_pix.size() != 0) @(posedge clk);
		repeat (320) @(posedge clk);
	endtask

	task automatic set_regs(logic [12:0] w, logic [12:0] h, logic [3:0] r, logic m);
		cfg_we <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_index <= REG_RADIUS;
		cfg_wdata <= {9'($urandom), r};
		@(posedge clk);
		cfg_index <= REG_MODE;
		cfg_wdata <= {12'($urandom), m};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one frame: pixels with stray early flushes, then mostly flushes until the last result
	task automatic run_frame(int noise, bit extremes);
		int n, lag, npend;
		n = tracker.eff_w() * tracker.eff_h();
		lag = tracker.eff_r() * tracker.eff_w() + tracker.eff_r();
		npend = n < lag ? n : lag;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < noise) send_request(8'($urandom), 1'b1);
			if (extremes) send_request($urandom_range(1) ? PixMax : 8'd0, 1'b0);
			else send_request(8'($urandom), 1'b0);
		end
		for (int i = 0; i < npend; i++) send_request(8'($urandom), $urandom_range(3) != 0);
	endtask

	initial begin
		int w, h;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturated sizes, abandoned after three pixels
		set_regs(13'h1FFF, 13'h1FFF, 4'd0, 1'b0);
		repeat (3) send_request(8'($urandom), 1'b0);
		drain();
		set_regs(13'd0, 13'd0, 4'd0, 1'b1);
		run_frame(0, 1);
		drain();
		set_regs(13'd1, 13'd1, 4'd15, 1'b1);
		run_frame(50, 1);
		drain();
		set_regs(13'd3, 13'd2, 4'd1, 1'b0);
		run_frame(30, 1);
		run_frame(0, 0);
		drain();

		while (sent < 550) begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 6);
			if ($urandom_range(9) == 0) w = 0;
			if ($urandom_range(9) == 0) h = 0;
			if (sent > 440) calm = 1'b1;
			set_regs(13'(w), 13'(h), 4'($urandom_range(0, 15)), 1'($urandom));
			repeat ($urandom_range(1, 2)) run_frame(5, $urandom_range(4) == 0);
			if ($urandom_range(5) == 0)
				repeat ($urandom_range(1, 8)) send_request(8'($urandom), 1'b0);
			drain();
		end

		if (tracker.mismatches == 0 && tracker.pending_pix.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
